/* hw/rtl/lla_pkg.sv */
package lla_pkg;

  // Fixed field widths of the item and result payloads
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int MASK_W     = 9;
  localparam int GRID_W_W   = 11;
  localparam int GRID_H_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MASK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MASK = 3'd3;

  // Reset values of the configuration registers
  localparam logic [GRID_W_W-1:0] RST_GRID_WIDTH   = 11'd64;
  localparam logic [GRID_H_W-1:0] RST_GRID_HEIGHT  = 13'd64;
  localparam logic [MASK_W-1:0]   RST_BIRTH_MASK   = 9'd8;
  localparam logic [MASK_W-1:0]   RST_SURVIVE_MASK = 9'd12;

  typedef struct packed {
    logic cell_req;
    logic pad;
  } in_item_t;

  typedef struct packed {
    logic             next_cell;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             frame_end;
  } out_item_t;

  // Window control from the raster sequencer
  typedef struct packed {
    logic shift;      // an item is processed this cycle
    logic row_start;  // item sits in column 0
    logic clear;      // frame restart
  } win_ctl_t;

endpackage

/* hw/rtl/lla_cell.sv */
module lla_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic       head,
  input  logic [1:0] head_d,
  input  logic [1:0] prev_d,
  output logic [1:0] q
);

  logic [1:0] q_r;
  logic [1:0] q_nxt;

  // Head cell takes the new column, others take their left neighbour
  always_comb begin
    q_nxt = q_r;
    if (shift) begin
      q_nxt = head ? head_d : prev_d;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

/* hw/rtl/lla_line.sv */
module lla_line #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [$clog2(MAX_WIDTH)-1:0] start,
  input  logic [1:0]                   din,
  output logic [1:0]                   tail
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [1:0] chain [MAX_WIDTH];

  // Delay line of MAX_WIDTH cells; entry point set by the row length,
  // so the tail always gives the column written one row earlier
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    logic [1:0] prev;
    if (i == 0) begin : g_first
      assign prev = din;
    end else begin : g_rest
      assign prev = chain[i-1];
    end
    lla_cell u_cell (
      .clk    (clk),
      .shift  (shift),
      .head   (start == CW'(i)),
      .head_d (din),
      .prev_d (prev),
      .q      (chain[i])
    );
  end

  assign tail = chain[MAX_WIDTH-1];

endmodule

/* hw/rtl/lla_window.sv */
module lla_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lla_pkg::win_ctl_t            ctl,
  input  logic [2:0]                   col,
  input  logic [lla_pkg::MASK_W-1:0]   birth_mask,
  input  logic [lla_pkg::MASK_W-1:0]   survive_mask,
  output logic                         next_cell
);
  import lla_pkg::*;

  logic [8:0] win_r;
  logic [8:0] win_nxt;
  logic [8:0] view;
  logic [3:0] n_live;
  logic [MASK_W-1:0] rule;

  // Centre and left columns come from the window; the right column is the
  // new one, or dead at the start of a row (last cell of previous row)
  assign view = {(ctl.row_start ? 3'b000 : col), win_r[8:3]};

  always_comb begin
    win_nxt = win_r;
    if (ctl.clear) begin
      win_nxt = '0;
    end else if (ctl.shift) begin
      win_nxt = ctl.row_start ? {col, 6'b0} : view;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  // Eight neighbours, centre bit excluded
  always_comb begin
    n_live = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        n_live = n_live + 4'(view[k]);
      end
    end
  end

  assign rule      = view[4] ? survive_mask : birth_mask;
  assign next_cell = rule[n_live];

endmodule

/* hw/rtl/life_like_automaton_step_core.sv */
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   lla_pkg::in_item_t (cell_req, pad)
// out_     output     out_valid/out_stall lla_pkg::out_item_t
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per clock while in_stall is low; the result of a cell leaves
// grid_width + 1 items after it enters, through a single output register.
// Row history sits in a MAX_WIDTH long chain of two-bit delay cells.
// Reset (rst_n low, synchronous) clears counters, window and the output valid flag.
// in_stall is raised only while a result is held and out_stall is high.
module life_like_automaton_step_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lla_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lla_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lla_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lla_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lla_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);        // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);    // row length
  localparam int RW = $clog2(MAX_HEIGHT);       // result row index
  localparam int HW = $clog2(MAX_HEIGHT + 2);   // input row incl. flush rows

  function automatic logic [WW-1:0] clamp_w(input logic [GRID_W_W-1:0] v);
    int t;
    t = int'(v);
    if (t == 0) t = 1;
    if (t > MAX_WIDTH) t = MAX_WIDTH;
    return WW'(t);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [GRID_H_W-1:0] v);
    int t;
    t = int'(v);
    if (t == 0) t = 1;
    if (t > MAX_HEIGHT) t = MAX_HEIGHT;
    return HW'(t);
  endfunction

  // Configuration
  logic [WW-1:0]     w_eff_r;
  logic [HW-1:0]     h_eff_r;
  logic [CW-1:0]     start_r;
  logic [MASK_W-1:0] birth_r;
  logic [MASK_W-1:0] survive_r;
  logic              cfg_wr;
  logic              size_wr;
  logic [WW-1:0]     w_new;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign size_wr   = cfg_wr && (cfg_index == CFG_GRID_WIDTH ||
                                cfg_index == CFG_GRID_HEIGHT);
  assign w_new     = clamp_w(cfg_data[GRID_W_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r   <= clamp_w(RST_GRID_WIDTH);
      start_r   <= CW'(MAX_WIDTH - int'(clamp_w(RST_GRID_WIDTH)));
      h_eff_r   <= clamp_h(RST_GRID_HEIGHT);
      birth_r   <= RST_BIRTH_MASK;
      survive_r <= RST_SURVIVE_MASK;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH: begin
          w_eff_r <= w_new;
          start_r <= CW'(MAX_WIDTH - int'(w_new));
        end
        CFG_GRID_HEIGHT:  h_eff_r   <= clamp_h(cfg_data);
        CFG_BIRTH_MASK:   birth_r   <= cfg_data[MASK_W-1:0];
        CFG_SURVIVE_MASK: survive_r <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster counters
  logic [CW-1:0] ic_r, ic_nxt;
  logic [HW-1:0] ir_r, ir_nxt;
  logic [CW-1:0] ec_r, ec_nxt;
  logic [RW-1:0] er_r, er_nxt;

  logic          accept;
  logic          proc;
  logic          emit;
  logic          last;
  logic          restart;
  logic [WW-1:0] ic_inc;
  logic [WW-1:0] ec_inc;
  logic [HW-1:0] er_inc;
  logic          bot;
  logic          mid;
  logic          top;
  logic [1:0]    tail;
  logic          next_cell;
  win_ctl_t      win_ctl;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_load;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  // A pad with no frame in progress is dropped
  assign proc     = accept && !(in_data.pad && ic_r == '0 && ir_r == '0);

  assign ic_inc = WW'(ic_r) + WW'(1);
  assign ec_inc = WW'(ec_r) + WW'(1);
  assign er_inc = HW'(er_r) + HW'(1);

  // Neighbourhood column; rows above the grid and flush rows read dead
  assign top = tail[1] && (ir_r >= HW'(2));
  assign mid = tail[0] && (ir_r >= HW'(1));
  assign bot = in_data.cell_req && !in_data.pad && (ir_r < h_eff_r);

  assign emit    = (ir_r >= HW'(2)) || (ir_r == HW'(1) && ic_r != '0);
  assign last    = (er_inc >= h_eff_r) && (ec_inc >= w_eff_r);
  assign restart = size_wr || (proc && emit && last);

  lla_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .shift (proc),
    .start (start_r),
    .din   ({mid, bot}),
    .tail  (tail)
  );

  assign win_ctl.shift     = proc;
  assign win_ctl.row_start = (ic_r == '0);
  assign win_ctl.clear     = restart;

  lla_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (win_ctl),
    .col          ({bot, mid, top}),
    .birth_mask   (birth_r),
    .survive_mask (survive_r),
    .next_cell    (next_cell)
  );

  // Counter update
  always_comb begin
    ic_nxt = ic_r;
    ir_nxt = ir_r;
    ec_nxt = ec_r;
    er_nxt = er_r;
    if (restart) begin
      ic_nxt = '0;
      ir_nxt = '0;
      ec_nxt = '0;
      er_nxt = '0;
    end else if (proc) begin
      if (ic_inc >= w_eff_r) begin
        ic_nxt = '0;
        ir_nxt = ir_r + HW'(1);
      end else begin
        ic_nxt = ic_inc[CW-1:0];
      end
      if (emit) begin
        if (ec_inc >= w_eff_r) begin
          ec_nxt = '0;
          er_nxt = er_inc[RW-1:0];
        end else begin
          ec_nxt = ec_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r <= '0;
      ir_r <= '0;
      ec_r <= '0;
      er_r <= '0;
    end else begin
      ic_r <= ic_nxt;
      ir_r <= ir_nxt;
      ec_r <= ec_nxt;
      er_r <= er_nxt;
    end
  end

  // Result register, reloaded whenever it is empty or being taken
  logic [31:0] ec_wide;
  logic [31:0] er_wide;

  assign ec_wide  = 32'(ec_r);
  assign er_wide  = 32'(er_r);
  assign out_load = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= proc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.next_cell <= next_cell;
      out_data_r.out_col   <= ec_wide[COL_W-1:0];
      out_data_r.out_row   <= er_wide[ROW_W-1:0];
      out_data_r.frame_end <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Column counters and the result row counter stay inside the grid
  a_ic_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(ic_r) < w_eff_r)
    else $error("input column beyond row length");

  a_ec_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(ec_r) < w_eff_r)
    else $error("result column beyond row length");

  a_er_range: assert property (@(posedge clk) disable iff (!rst_n)
    HW'(er_r) < h_eff_r)
    else $error("result row beyond grid height");

  // Last cell of the frame returns the raster to the origin
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && emit && last) |=> (ic_r == '0 && ir_r == '0 && ec_r == '0 && er_r == '0))
    else $error("frame end did not restart the raster");

endmodule
